// ===== hw/rtl/status_led_animator_defines.svh =====
// Assertion macros shared by the status LED animator RTL.
`ifndef STATUS_LED_ANIMATOR_DEFINES_SVH
`define STATUS_LED_ANIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when cond holds, check must hold in that cycle.
`define SLA_ASSERT_NOW(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("status_led_animator: check failed");
// Next-cycle implication: when cond holds, check must hold in the next cycle.
`define SLA_ASSERT_NEXT(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("status_led_animator: check failed");
`else
`define SLA_ASSERT_NOW(label, clk, rst, cond, check)
`define SLA_ASSERT_NEXT(label, clk, rst, cond, check)
`endif
`endif

// ===== hw/rtl/sla_pkg.sv =====
// Shared types, constants and the sine table generator for the status LED animator.
package sla_pkg;

   // Default number of quarter-wave sine table steps.
   localparam int unsigned SINE_DEPTH_DEFAULT = 256;

   // Fixed-point constants of the sine polynomial (Q30).
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Q0.16 dim value of 1.0.
   localparam logic [16:0] DIM_ONE = 17'd65536;

   // Serial multiplier geometry: radix-16 digits of the B operand.
   localparam int unsigned MAC_A_WIDTH = 32;
   localparam int unsigned MAC_B_WIDTH = 16;
   localparam int unsigned MAC_P_WIDTH = 48;
   localparam int unsigned MAC_DIGIT   = 4;
   localparam logic [1:0]  MAC_LAST_STEP  = 2'(MAC_B_WIDTH / MAC_DIGIT - 1);
   // The sine lookup has two register stages.
   localparam logic [1:0]  SINE_LAST_STEP = 2'd1;

   // Configuration register width and indexes.
   localparam int unsigned CSR_DATA_WIDTH = 24;
   typedef enum logic [0:0] {
      CSR_TUBE_LIFE      = 1'b0,
      CSR_DONE_FADE_STEP = 1'b1
   } csr_index_type;

   // Pump state codes.
   localparam logic [2:0] PUMP_IDLE      = 3'd0;
   localparam logic [2:0] PUMP_RUNNING   = 3'd1;
   localparam logic [2:0] PUMP_PAUSED    = 3'd2;
   localparam logic [2:0] PUMP_DONE      = 3'd3;
   localparam logic [2:0] PUMP_ANTI_DRIP = 3'd4;

   // Pump mode codes.
   localparam logic [1:0] MODE_DOSE  = 2'd0;
   localparam logic [1:0] MODE_TIMED = 2'd1;
   localparam logic [1:0] MODE_BURST = 2'd2;

   // Frame sequencer states.
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_BLINK_ANGLE,
      SEQ_BLINK_SINE,
      SEQ_PULSE_ANGLE,
      SEQ_PULSE_SINE,
      SEQ_DIM_MUL,
      SEQ_DIM_SET,
      SEQ_COLOR_MUL,
      SEQ_OUTPUT
   } seq_state_type;

   // Input word: one animation frame.
   typedef struct packed {
      logic [2:0]  run_state;
      logic [1:0]  pump_mode;
      logic [23:0] dispensed;
   } req_word_type;

   // Output word: one dimmed RGB color.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_word_type;

   // One sine table entry in Q15 from a Q30 angle, by a 9th-order Taylor
   // polynomial in Horner form. Evaluated only at elaboration.
   function automatic logic [15:0] sine_entry(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32768) begin
         s = 64'd32768;
      end
      return s[15:0];
   endfunction

endpackage

// ===== hw/rtl/sla_mac.sv =====
// Radix-16 digit-serial multiplier with a held product.
module sla_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sla_pkg::MAC_A_WIDTH-1:0]  a,
   input  logic [sla_pkg::MAC_B_WIDTH-1:0]  b,
   output logic [sla_pkg::MAC_P_WIDTH-1:0]  product
);
   import sla_pkg::*;

   localparam int unsigned DigitCount = MAC_B_WIDTH / MAC_DIGIT;
   localparam int unsigned LeftWidth  = $clog2(DigitCount);

   logic [MAC_P_WIDTH-1:0] acc_ff, acc_in;
   logic [MAC_P_WIDTH-1:0] mcand_ff, mcand_in;
   logic [MAC_B_WIDTH-1:0] mplier_ff, mplier_in;
   logic [LeftWidth-1:0]   left_ff, left_in;

   logic [MAC_P_WIDTH-1:0] mcand_src;
   logic [MAC_B_WIDTH-1:0] mplier_src;
   logic [MAC_P_WIDTH-1:0] acc_base;
   logic                   step;

   // A start takes the first digit from the ports; later digits come from the shift registers.
   always_comb begin
      if (start) begin
         mcand_src  = MAC_P_WIDTH'(a);
         mplier_src = b;
         acc_base   = '0;
      end else begin
         mcand_src  = mcand_ff;
         mplier_src = mplier_ff;
         acc_base   = acc_ff;
      end
      step = start || (left_ff != '0);
   end

   // One digit is multiplied and added per cycle; the product holds when done.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      left_in   = left_ff;
      if (step) begin
         acc_in    = acc_base
                   + mcand_src * MAC_P_WIDTH'(mplier_src[MAC_DIGIT-1:0]);
         mcand_in  = mcand_src << MAC_DIGIT;
         mplier_in = mplier_src >> MAC_DIGIT;
      end
      if (start) begin
         left_in = LeftWidth'(DigitCount - 1);
      end else if (left_ff != '0) begin
         left_in = left_ff - LeftWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product = acc_ff;

endmodule

// ===== hw/rtl/sla_sine.sv =====
// Quarter-wave sine lookup with a two-stage registered read.
module sla_sine #(
   parameter int unsigned SINE_TABLE_DEPTH = sla_pkg::SINE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic [15:0]        angle,
   output logic signed [16:0] sine
);
   import sla_pkg::*;

   localparam int unsigned IdxWidth    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned ScaledWidth = 14 + IdxWidth;

   logic [15:0] sine_rom [0:SINE_TABLE_DEPTH];

   // Constant table of one quarter wave, built at elaboration.
   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_entry
      localparam logic [63:0] XQ30 = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      assign sine_rom[i] = sine_entry(XQ30);
   end

   logic [ScaledWidth-1:0] scaled;
   logic [IdxWidth-1:0]    raw_idx;
   logic [IdxWidth-1:0]    idx_ff, idx_in;
   logic                   neg_ff, neg_in;
   logic signed [16:0]     sine_ff, sine_in;

   // Stage one: scale the in-quadrant angle to an index and mirror falling quadrants.
   always_comb begin
      scaled  = ScaledWidth'(angle[13:0]) * ScaledWidth'(SINE_TABLE_DEPTH);
      raw_idx = scaled[ScaledWidth-1:14];
      idx_in  = angle[14] ? (IdxWidth'(SINE_TABLE_DEPTH) - raw_idx) : raw_idx;
      neg_in  = angle[15];
   end

   // Stage two: read the magnitude and apply the sign of the lower half turn.
   always_comb begin
      if (neg_ff) begin
         sine_in = -$signed({1'b0, sine_rom[idx_ff]});
      end else begin
         sine_in = $signed({1'b0, sine_rom[idx_ff]});
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      neg_ff  <= neg_in;
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

// ===== hw/rtl/status_led_animator.sv =====
// Top level of the status LED animator: frame sequencer, registers and result stage.

// Each accepted word is one animation frame and yields exactly one RGB word.
// The input side stays stalled until the sequencer is back in idle, so a new
// word is taken only once the previous frame's color is loaded into the
// output register; a stalled output holds the sequencer in its final state
// until the register frees. A frame makes four passes through the shared
// radix-16 serial multiplier (blink angle, pulse angle, dim product, and the
// color scaling, which runs on three multipliers side by side), two reads of
// the two-stage sine table, a step to settle the dim factor and a step to
// load the output. Configuration writes take effect at once and are meant
// for idle periods only.
`include "status_led_animator_defines.svh"

module status_led_animator #(
   parameter int unsigned SINE_TABLE_DEPTH = sla_pkg::SINE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  sla_pkg::csr_index_type              csr_index,
   input  logic [sla_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sla_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sla_pkg::rsp_word_type               rsp_word
);
   import sla_pkg::*;

   // Pulse shapes in Q0.16 and angle steps in 16-bit turns.
   localparam logic [15:0] BLINK_INC      = 16'd313;
   localparam logic [15:0] IDLE_INC       = 16'd209;
   localparam logic [15:0] PAUSED_INC     = 16'd1043;
   localparam logic [15:0] ANTI_DRIP_INC  = 16'd3129;
   localparam logic [15:0] IDLE_BASE      = 16'd6554;
   localparam logic [15:0] IDLE_AMP       = 16'd9830;
   localparam logic [15:0] PULSE_BASE     = 16'd19661;
   localparam logic [15:0] PULSE_AMP      = 16'd22938;
   localparam logic [16:0] DIM_RUNNING    = 17'd45875;
   localparam logic [16:0] DIM_BLINK      = 17'd32768;
   localparam logic signed [16:0] BLINK_THRESHOLD = 17'sd22938;
   localparam logic [15:0] FADE_RESET     = 16'd874;

   // Base color levels.
   localparam logic [7:0] LVL_IDLE_GREEN  = 8'd30;
   localparam logic [7:0] LVL_JET         = 8'd30;
   localparam logic [7:0] LVL_TIMED_GREEN = 8'd20;
   localparam logic [7:0] LVL_TIMED_BLUE  = 8'd60;
   localparam logic [7:0] LVL_VOLUME_BLUE = 8'd80;
   localparam logic [7:0] LVL_AMBER_RED   = 8'd60;
   localparam logic [7:0] LVL_AMBER_GREEN = 8'd30;
   localparam logic [7:0] LVL_DONE_GREEN  = 8'd180;
   localparam logic [7:0] LVL_CYAN        = 8'd50;
   localparam logic [7:0] LVL_WARN_RED    = 8'd80;

   // Sequencer and frame state.
   seq_state_type state_ff, state_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [31:0]   phase_ff, phase_in;
   logic [2:0]    pstate_ff, pstate_in;
   logic [1:0]    pmode_ff, pmode_in;
   logic          warn_ff, warn_in;
   logic [23:0]   tube_life_ff, tube_life_in;
   logic [15:0]   fade_ff, fade_in;
   logic          blink_ff, blink_in;
   logic [16:0]   dim_ff, dim_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // Combinational helpers.
   logic                   accept;
   logic                   out_free;
   logic                   warn_now;
   logic                   change;
   logic [26:0]            five_disp;
   logic [26:0]            four_life;
   logic                   mac_start;
   logic                   color_start;
   logic                   blink_load;
   logic                   dim_load;
   logic                   rsp_load;
   logic [MAC_A_WIDTH-1:0] mac_a;
   logic [MAC_B_WIDTH-1:0] mac_b;
   logic [MAC_P_WIDTH-1:0] red_prod;
   logic [MAC_P_WIDTH-1:0] green_prod;
   logic [MAC_P_WIDTH-1:0] blue_prod;
   logic signed [16:0]     sine_q15;
   logic [16:0]            one_plus;
   logic [15:0]            pulse_inc;
   logic [15:0]            pulse_base;
   logic [15:0]            pulse_amp;
   logic [17:0]            pulse_sum;
   logic [16:0]            dim_pulse;
   logic [16:0]            dim_done;
   logic [7:0]             base_red;
   logic [7:0]             base_green;
   logic [7:0]             base_blue;

   // Handshake on both channels.
   assign req_stall = reset || (state_ff != SEQ_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Tube wear test and frame phase update on each accepted word.
   always_comb begin
      five_disp = 27'({req_word.dispensed, 2'b00}) + 27'(req_word.dispensed);
      four_life = 27'({tube_life_ff, 2'b00});
      warn_now  = (tube_life_ff != '0) && (five_disp > four_life);
      change    = (req_word.run_state != pstate_ff) || (req_word.pump_mode != pmode_ff)
                || (warn_now != warn_ff);
      phase_in  = phase_ff;
      pstate_in = pstate_ff;
      pmode_in  = pmode_ff;
      warn_in   = warn_ff;
      if (accept) begin
         phase_in  = change ? 32'd1 : (phase_ff + 32'd1);
         pstate_in = req_word.run_state;
         pmode_in  = req_word.pump_mode;
         warn_in   = warn_now;
      end
   end

   // Configuration registers.
   always_comb begin
      tube_life_in = tube_life_ff;
      fade_in      = fade_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TUBE_LIFE:      tube_life_in = csr_write_data;
            CSR_DONE_FADE_STEP: fade_in      = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Pulse shape for the current pump state.
   always_comb begin
      pulse_inc  = '0;
      pulse_base = '0;
      pulse_amp  = '0;
      case (pstate_ff)
         PUMP_IDLE: begin
            pulse_inc  = IDLE_INC;
            pulse_base = IDLE_BASE;
            pulse_amp  = IDLE_AMP;
         end
         PUMP_PAUSED: begin
            pulse_inc  = PAUSED_INC;
            pulse_base = PULSE_BASE;
            pulse_amp  = PULSE_AMP;
         end
         PUMP_ANTI_DRIP: begin
            pulse_inc  = ANTI_DRIP_INC;
            pulse_base = PULSE_BASE;
            pulse_amp  = PULSE_AMP;
         end
         default: ;
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:        if (accept) state_in = SEQ_BLINK_ANGLE;
         SEQ_BLINK_ANGLE: if (cnt_ff == MAC_LAST_STEP) state_in = SEQ_BLINK_SINE;
         SEQ_BLINK_SINE:  if (cnt_ff == SINE_LAST_STEP) state_in = SEQ_PULSE_ANGLE;
         SEQ_PULSE_ANGLE: if (cnt_ff == MAC_LAST_STEP) state_in = SEQ_PULSE_SINE;
         SEQ_PULSE_SINE:  if (cnt_ff == SINE_LAST_STEP) state_in = SEQ_DIM_MUL;
         SEQ_DIM_MUL:     if (cnt_ff == MAC_LAST_STEP) state_in = SEQ_DIM_SET;
         SEQ_DIM_SET:     state_in = SEQ_COLOR_MUL;
         SEQ_COLOR_MUL:   if (cnt_ff == MAC_LAST_STEP) state_in = SEQ_OUTPUT;
         SEQ_OUTPUT:      if (out_free) state_in = SEQ_IDLE;
         default:         state_in = SEQ_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? 2'd0 : (cnt_ff + 2'd1);
   end

   // Sequencer outputs: multiplier operands and load strobes.
   always_comb begin
      mac_start   = 1'b0;
      color_start = 1'b0;
      blink_load  = 1'b0;
      dim_load    = 1'b0;
      rsp_load    = 1'b0;
      mac_a       = '0;
      mac_b       = '0;
      case (state_ff)
         SEQ_BLINK_ANGLE: begin
            mac_start = (cnt_ff == '0);
            mac_a     = MAC_A_WIDTH'(phase_ff[15:0]);
            mac_b     = BLINK_INC;
         end
         SEQ_PULSE_ANGLE: begin
            blink_load = (cnt_ff == '0);
            mac_start  = (cnt_ff == '0);
            mac_a      = MAC_A_WIDTH'(phase_ff[15:0]);
            mac_b      = pulse_inc;
         end
         SEQ_DIM_MUL: begin
            mac_start = (cnt_ff == '0);
            if (pstate_ff == PUMP_DONE) begin
               mac_a = phase_ff;
               mac_b = fade_ff;
            end else begin
               mac_a = MAC_A_WIDTH'(one_plus);
               mac_b = pulse_amp;
            end
         end
         SEQ_DIM_SET: dim_load = 1'b1;
         SEQ_COLOR_MUL: begin
            mac_start   = (cnt_ff == '0);
            color_start = (cnt_ff == '0);
            mac_a       = MAC_A_WIDTH'(dim_ff);
            mac_b       = MAC_B_WIDTH'(base_red);
         end
         SEQ_OUTPUT: rsp_load = out_free;
         default: ;
      endcase
   end

   // Shared multiplier; it also scales the red channel.
   sla_mac u_mac_red (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .a       (mac_a),
      .b       (mac_b),
      .product (red_prod)
   );

   sla_mac u_mac_green (
      .clock   (clock),
      .reset   (reset),
      .start   (color_start),
      .a       (MAC_A_WIDTH'(dim_ff)),
      .b       (MAC_B_WIDTH'(base_green)),
      .product (green_prod)
   );

   sla_mac u_mac_blue (
      .clock   (clock),
      .reset   (reset),
      .start   (color_start),
      .a       (MAC_A_WIDTH'(dim_ff)),
      .b       (MAC_B_WIDTH'(base_blue)),
      .product (blue_prod)
   );

   // The sine table reads the angle held in the shared multiplier.
   sla_sine #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock (clock),
      .angle (red_prod[15:0]),
      .sine  (sine_q15)
   );

   // Red blink overlay: worn tube, idle or done, and the slow sine at or above 0.7.
   always_comb begin
      blink_in = blink_ff;
      if (blink_load) begin
         blink_in = warn_ff && ((pstate_ff == PUMP_IDLE) || (pstate_ff == PUMP_DONE))
                 && (sine_q15 >= BLINK_THRESHOLD);
      end
   end

   // Dim factor: pulse with clamp, linear fade with floor, or fixed level.
   always_comb begin
      one_plus  = 17'(18'd32768 + {sine_q15[16], sine_q15});
      pulse_sum = 18'(pulse_base) + 18'(red_prod[31:15]);
      dim_pulse = (pulse_sum > 18'(DIM_ONE)) ? DIM_ONE : pulse_sum[16:0];
      dim_done  = (red_prod[47:16] != '0) ? 17'd0 : (DIM_ONE - 17'(red_prod[15:0]));
      dim_in    = dim_ff;
      if (dim_load) begin
         case (pstate_ff)
            PUMP_IDLE, PUMP_PAUSED, PUMP_ANTI_DRIP: dim_in = dim_pulse;
            PUMP_RUNNING:                           dim_in = DIM_RUNNING;
            PUMP_DONE:                              dim_in = dim_done;
            default:                                dim_in = '0;
         endcase
         if (blink_ff) begin
            dim_in = DIM_BLINK;
         end
      end
   end

   // Base color of the frame.
   always_comb begin
      base_red   = '0;
      base_green = '0;
      base_blue  = '0;
      case (pstate_ff)
         PUMP_IDLE: base_green = LVL_IDLE_GREEN;
         PUMP_RUNNING: begin
            case (pmode_ff)
               MODE_BURST: begin
                  base_red  = LVL_JET;
                  base_blue = LVL_JET;
               end
               MODE_TIMED: begin
                  base_green = LVL_TIMED_GREEN;
                  base_blue  = LVL_TIMED_BLUE;
               end
               default: base_blue = LVL_VOLUME_BLUE;
            endcase
         end
         PUMP_PAUSED: begin
            base_red   = LVL_AMBER_RED;
            base_green = LVL_AMBER_GREEN;
         end
         PUMP_DONE: base_green = LVL_DONE_GREEN;
         PUMP_ANTI_DRIP: begin
            base_green = LVL_CYAN;
            base_blue  = LVL_CYAN;
         end
         default: ;
      endcase
      if (blink_ff) begin
         base_red   = LVL_WARN_RED;
         base_green = '0;
         base_blue  = '0;
      end
   end

   // Output register: loads the scaled color when free, drains when taken.
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_word_in.red   = red_prod[23:16];
         rsp_word_in.green = green_prod[23:16];
         rsp_word_in.blue  = blue_prod[23:16];
         rsp_valid_in      = 1'b1;
      end
   end

   // Control and frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         pstate_ff    <= PUMP_IDLE;
         pmode_ff     <= MODE_DOSE;
         warn_ff      <= 1'b0;
         tube_life_ff <= '0;
         fade_ff      <= FADE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         pstate_ff    <= pstate_in;
         pmode_ff     <= pmode_in;
         warn_ff      <= warn_in;
         tube_life_ff <= tube_life_in;
         fade_ff      <= fade_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      blink_ff    <= blink_in;
      dim_ff      <= dim_in;
      rsp_word_ff <= rsp_word_in;
   end

   // An accepted word keeps the input side stalled in the next cycle.
   `SLA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   // A new result appears only out of the final sequencer state.
   `SLA_ASSERT_NOW(a_load_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == SEQ_OUTPUT)
   // The dim factor used for scaling never exceeds one.
   `SLA_ASSERT_NOW(a_dim_range, clock, reset, state_ff == SEQ_COLOR_MUL, dim_ff <= DIM_ONE)

endmodule

// ===== tb/sv/status_led_animator_checker.sv =====
// Checker for the status LED animator: predicts each frame color and compares results.
module status_led_animator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  sla_pkg::csr_index_type             csr_index,
   input  logic [sla_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  sla_pkg::req_word_type              req_word,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  sla_pkg::rsp_word_type              rsp_word,
   output int                                 mismatch_count,
   output int                                 colors_waiting
);
   import sla_pkg::*;

   localparam int unsigned DEPTH = SINE_DEPTH_DEFAULT;

   // Q30 polynomial constants and Q0.16 dim levels.
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned QUARTER_Q30 = 64'd1686629713;
   localparam int unsigned FULL_DIM        = 65536;
   localparam int unsigned HALF_DIM        = 32768;
   localparam int unsigned RUN_DIM         = 45875;
   localparam int unsigned IDLE_FLOOR      = 6554;
   localparam int unsigned IDLE_SWING      = 9830;
   localparam int unsigned PULSE_FLOOR     = 19661;
   localparam int unsigned PULSE_SWING     = 22938;
   localparam int          BLINK_LEVEL     = 22938;

   // Turn-angle increments per frame for each animation.
   localparam int unsigned IDLE_TURN  = 209;
   localparam int unsigned PAUSE_TURN = 1043;
   localparam int unsigned DRIP_TURN  = 3129;
   localparam int unsigned BLINK_TURN = 313;

   int unsigned   quarter_wave [0:DEPTH];
   logic [23:0]   tube_life;
   logic [15:0]   fade_step;
   logic [31:0]   frame_phase;
   logic [2:0]    last_state;
   logic [1:0]    last_mode;
   logic          last_warn;
   rsp_word_type  predicted_colors [$];
   rsp_word_type  oldest;
   int            errors = 0;

   // One quarter-wave entry in Q15 from a Q30 angle, Horner form of the Taylor series.
   function automatic int unsigned sine_point(input longint unsigned x);
      longint unsigned sq;
      longint unsigned h;
      longint unsigned s;
      sq = (x * x) >> 30;
      h  = ONE_Q30 - sq / 72;
      h  = ONE_Q30 - ((sq * h) >> 30) / 42;
      h  = ONE_Q30 - ((sq * h) >> 30) / 20;
      h  = ONE_Q30 - ((sq * h) >> 30) / 6;
      s  = (x * h) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32768) begin
         s = 64'd32768;
      end
      return int'(s);
   endfunction

   initial begin
      for (int i = 0; i <= DEPTH; i++) begin
         quarter_wave[i] = sine_point((QUARTER_Q30 * 64'(i)) / 64'(DEPTH));
      end
   end

   // Signed Q15 sine of phase times a turn increment, folded from the quarter wave.
   function automatic int table_sine(input logic [31:0] phase, input int unsigned turn);
      logic [31:0] angle;
      int unsigned idx;
      int          mag;
      angle = phase * turn;
      idx   = (int'(angle[13:0]) * DEPTH) >> 14;
      if (angle[14]) begin
         idx = DEPTH - idx;
      end
      mag = int'(quarter_wave[idx]);
      return angle[15] ? -mag : mag;
   endfunction

   // Breathing dim: floor plus swing times (1 + sine), clamped to full scale.
   function automatic int unsigned breathing_dim(input int unsigned floor_level,
                                                 input int unsigned swing,
                                                 input int unsigned turn);
      longint unsigned one_plus;
      longint unsigned level;
      one_plus = longint'(32768 + table_sine(frame_phase, turn));
      level    = floor_level + ((swing * one_plus) >> 15);
      return (level > FULL_DIM) ? FULL_DIM : int'(level);
   endfunction

   // Advances the frame state by one word and returns the color it should show.
   function automatic rsp_word_type next_color(input req_word_type w);
      logic            warn;
      longint unsigned fall;
      int unsigned     r;
      int unsigned     g;
      int unsigned     b;
      int unsigned     dim;
      rsp_word_type    c;
      warn = (tube_life != 0) && (64'(w.dispensed) * 5 > 64'(tube_life) * 4);
      if (w.run_state != last_state || w.pump_mode != last_mode || warn != last_warn) begin
         frame_phase = '0;
      end
      last_state  = w.run_state;
      last_mode   = w.pump_mode;
      last_warn   = warn;
      frame_phase = frame_phase + 32'd1;
      r   = 0;
      g   = 0;
      b   = 0;
      dim = FULL_DIM;
      case (w.run_state)
         PUMP_IDLE: begin
            g   = 30;
            dim = breathing_dim(IDLE_FLOOR, IDLE_SWING, IDLE_TURN);
         end
         PUMP_RUNNING: begin
            case (w.pump_mode)
               MODE_BURST: begin
                  r = 30;
                  b = 30;
               end
               MODE_TIMED: begin
                  g = 20;
                  b = 60;
               end
               default: b = 80;
            endcase
            dim = RUN_DIM;
         end
         PUMP_PAUSED: begin
            r   = 60;
            g   = 30;
            dim = breathing_dim(PULSE_FLOOR, PULSE_SWING, PAUSE_TURN);
         end
         PUMP_DONE: begin
            // Linear fade that sticks at zero once the product passes full scale.
            fall = 64'(frame_phase) * 64'(fade_step);
            g    = 180;
            dim  = (fall >= FULL_DIM) ? 0 : FULL_DIM - int'(fall);
         end
         PUMP_ANTI_DRIP: begin
            g   = 50;
            b   = 50;
            dim = breathing_dim(PULSE_FLOOR, PULSE_SWING, DRIP_TURN);
         end
         default: dim = FULL_DIM;
      endcase
      // Worn tube: red blink over idle and done near the sine crest.
      if (warn && (w.run_state == PUMP_IDLE || w.run_state == PUMP_DONE) &&
          table_sine(frame_phase, BLINK_TURN) >= BLINK_LEVEL) begin
         r   = 80;
         g   = 0;
         b   = 0;
         dim = HALF_DIM;
      end
      c.red   = 8'((r * dim) >> 16);
      c.green = 8'((g * dim) >> 16);
      c.blue  = 8'((b * dim) >> 16);
      return c;
   endfunction

   task automatic check_channel(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         errors++;
      end
   endtask

   // Track register writes, predict on each accepted request, compare each result.
   always @(posedge clock) begin
      if (reset) begin
         tube_life   = '0;
         fade_step   = 16'd874;
         frame_phase = '0;
         last_state  = PUMP_IDLE;
         last_mode   = MODE_DOSE;
         last_warn   = 1'b0;
         predicted_colors.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TUBE_LIFE:      tube_life = csr_write_data;
               CSR_DONE_FADE_STEP: fade_step = csr_write_data[15:0];
               default:            ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_colors.size() == 0) begin
               $display("%0t: color expected none, got %h", $time, rsp_word);
               errors++;
            end else begin
               oldest = predicted_colors.pop_front();
               check_channel("red", oldest.red, rsp_word.red);
               check_channel("green", oldest.green, rsp_word.green);
               check_channel("blue", oldest.blue, rsp_word.blue);
            end
         end
         if (req_valid && !req_stall) begin
            predicted_colors.push_back(next_color(req_word));
         end
      end
      colors_waiting <= predicted_colors.size();
      mismatch_count <= errors;
   end

endmodule

// ===== tb/sv/tb_status_led_animator.sv =====
// Testbench top for the status LED animator: clock, reset, frame stimulus and verdict.
module tb_status_led_animator;
   import sla_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_enable = 1'b0;
   csr_index_type               csr_index = CSR_TUBE_LIFE;
   logic [CSR_DATA_WIDTH-1:0]   csr_write_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   req_word_type                req_word = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   rsp_word_type                rsp_word;
   int                          mismatch_count;
   int                          colors_waiting;

   logic [23:0] tube_setting = '0;
   int          burst_left = 1;
   int          stall_left = 0;
   int          stall_kind = 0;
   int          idle_cycles = 0;

   status_led_animator dut (.*);
   status_led_animator_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls in segments: free running, random, or held solid.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 2);
         stall_left <= $urandom_range(1, 40);
         rsp_stall  <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_kind)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   // Watchdog: too long without any word moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status_led_animator: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one frame word; bursts end with a random gap, sometimes none, on the request side.
   task automatic send_frame(input logic [2:0] st, input logic [1:0] md,
                             input logic [23:0] disp);
      int gap;
      req_valid <= 1'b1;
      req_word  <= '{run_state: st, pump_mode: md, dispensed: disp};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 6);
      end
   endtask

   // Stops sending and waits until every predicted color has come back.
   task automatic wait_for_colors();
      req_valid <= 1'b0;
      @(posedge clock);
      while (colors_waiting != 0) @(posedge clock);
   endtask

   // Writes both registers on back-to-back edges while the block is idle.
   task automatic apply_settings(input logic [23:0] tube, input logic [15:0] fade);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TUBE_LIFE;
      csr_write_data   <= tube;
      @(posedge clock);
      csr_index        <= CSR_DONE_FADE_STEP;
      csr_write_data   <= {8'($urandom), fade};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tube_setting = tube;
   endtask

   // Dispensed volume on the requested side of the wear threshold.
   function automatic logic [23:0] pick_dispensed(input bit over);
      longint unsigned limit;
      if (tube_setting == 0) begin
         return 24'($urandom);
      end
      limit = (64'(tube_setting) * 4) / 5;
      if ($urandom_range(0, 7) == 0) begin
         return over ? 24'(limit + 1) : 24'(limit);
      end
      if (over) begin
         return 24'($urandom_range(32'hFFFFFF, 32'(limit) + 1));
      end
      return 24'($urandom_range(32'(limit), 0));
   endfunction

   // Runs of frames that hold state and mode, with noise words and stray warnings.
   task automatic run_random(input int count);
      int          sent;
      int          len;
      bit          long_run;
      bit          warn_on;
      logic [2:0]  st;
      logic [1:0]  md;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_frame(3'($urandom), 2'($urandom), 24'($urandom));
            sent++;
         end else begin
            long_run = ($urandom_range(0, 3) == 0);
            warn_on  = $urandom_range(0, 1);
            st       = 3'($urandom_range(0, 15));
            st       = (st >= 3'd5 && $urandom_range(0, 3) != 0) ? 3'(st % 5) : st;
            if (long_run && $urandom_range(0, 1)) begin
               st      = $urandom_range(0, 1) ? PUMP_DONE : PUMP_IDLE;
               warn_on = ($urandom_range(0, 3) != 0);
            end
            md  = 2'($urandom_range(0, 3));
            len = long_run ? $urandom_range(40, 110) : $urandom_range(1, 8);
            for (int i = 0; i < len && sent < count; i++) begin
               send_frame(st, md, pick_dispensed(($urandom_range(0, 29) == 0) ? !warn_on
                                                                             : warn_on));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: every state and mode, unknown codes, wear threshold edges.
      apply_settings(24'd1000, 16'd874);
      send_frame(PUMP_IDLE, MODE_DOSE, 24'd0);
      send_frame(PUMP_IDLE, MODE_DOSE, 24'd0);
      send_frame(PUMP_RUNNING, MODE_DOSE, 24'd10);
      send_frame(PUMP_RUNNING, MODE_TIMED, 24'd10);
      send_frame(PUMP_RUNNING, MODE_BURST, 24'd10);
      send_frame(PUMP_RUNNING, 2'd3, 24'd10);
      send_frame(PUMP_PAUSED, MODE_DOSE, 24'd20);
      send_frame(PUMP_ANTI_DRIP, MODE_TIMED, 24'd20);
      send_frame(PUMP_DONE, MODE_DOSE, 24'd30);
      send_frame(PUMP_DONE, MODE_DOSE, 24'd30);
      send_frame(3'd5, MODE_DOSE, 24'd0);
      send_frame(3'd6, 2'd3, 24'd500);
      send_frame(3'd7, MODE_BURST, 24'hFFFFFF);
      send_frame(PUMP_IDLE, MODE_DOSE, 24'd800);
      send_frame(PUMP_IDLE, MODE_DOSE, 24'd801);
      send_frame(PUMP_DONE, MODE_DOSE, 24'hFFFFFF);
      send_frame(PUMP_PAUSED, 2'd3, 24'd801);
      wait_for_colors();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       apply_settings(24'd0, 16'd0);
            1:       apply_settings(24'hFFFFFF, 16'hFFFF);
            2:       apply_settings(24'd1, 16'd874);
            3:       apply_settings(24'($urandom_range(1, 32'hFFFFFF)),
                                    16'($urandom_range(0, 3000)));
            default: apply_settings(24'd1000, 16'd1);
         endcase
         run_random(375);
         wait_for_colors();
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && colors_waiting == 0) begin
         $display("status_led_animator: match");
      end else begin
         $display("status_led_animator: mismatch");
      end
      $finish;
   end

endmodule
